// File: rtl/nslb_pkg.sv
package nslb_pkg;

  localparam int MAX_DIM = 1024;
  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int CNT_W   = $clog2(MAX_DIM);
  localparam int CFG_W   = 11;
  localparam int STEP_W  = 27;
  localparam int FRAC_W  = 16;
  localparam int SPOS_W  = STEP_W - FRAC_W;
  localparam int ADDR_W  = 20;
  localparam int CIDX_W  = 3;
  localparam int CDATA_W = STEP_W;

  typedef enum logic [CIDX_W-1:0] {
    CFG_SRC_WIDTH  = 3'd0,
    CFG_SRC_HEIGHT = 3'd1,
    CFG_SCR_WIDTH  = 3'd2,
    CFG_SCR_HEIGHT = 3'd3,
    CFG_SCR_STRIDE = 3'd4,
    CFG_COL_STEP   = 3'd5,
    CFG_ROW_STEP   = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [CFG_W-1:0]  src_w;
    logic [CFG_W-1:0]  src_h;
    logic [CFG_W-1:0]  scr_w;
    logic [CFG_W-1:0]  scr_h;
    logic [CFG_W-1:0]  stride;
    logic [STEP_W-1:0] col_step;
    logic [STEP_W-1:0] row_step;
  } cfg_t;

  typedef struct packed {
    logic [DIM_W-1:0]  sw;
    logic [DIM_W-1:0]  sh;
    logic [DIM_W-1:0]  dh;
    logic [DIM_W-1:0]  st;
    logic [DIM_W-1:0]  rowlen;
    logic [CNT_W-1:0]  sw_m1;
    logic [CNT_W-1:0]  sh_m1;
    logic [CNT_W-1:0]  dx;
    logic [CNT_W-1:0]  dy;
    logic              down;
    logic [STEP_W-1:0] col_step;
    logic [STEP_W-1:0] row_step;
  } geom_t;

  typedef struct packed {
    logic [CNT_W-1:0]  row;
    logic [CNT_W-1:0]  col;
    logic [STEP_W-1:0] col_acc;
    logic [STEP_W-1:0] row_acc;
    logic              last;
  } pos_t;

  localparam cfg_t CFG_RESET = '{
    src_w:    CFG_W'(320),
    src_h:    CFG_W'(240),
    scr_w:    CFG_W'(320),
    scr_h:    CFG_W'(240),
    stride:   CFG_W'(320),
    col_step: STEP_W'(65536),
    row_step: STEP_W'(65536)
  };

  // A zero dimension counts as one, and a dimension above the maximum counts as the maximum.
  function automatic logic [DIM_W-1:0] dim_of(logic [CFG_W-1:0] v);
    logic [DIM_W-1:0] r;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (32'(v) > 32'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end else begin
      r = DIM_W'(v);
    end
    return r;
  endfunction

  function automatic geom_t derive(cfg_t c);
    geom_t            g;
    logic [DIM_W-1:0] sw;
    logic [DIM_W-1:0] sh;
    logic [DIM_W-1:0] dw;
    logic [DIM_W-1:0] dh;
    logic [DIM_W-1:0] st;
    logic [DIM_W-1:0] gx;
    logic [DIM_W-1:0] gy;
    sw = dim_of(c.src_w);
    sh = dim_of(c.src_h);
    dw = dim_of(c.scr_w);
    dh = dim_of(c.scr_h);
    st = dim_of(c.stride);
    if (st < dw) begin
      st = dw;
    end
    gx         = dw - sw;
    gy         = dh - sh;
    g.sw       = sw;
    g.sh       = sh;
    g.dh       = dh;
    g.st       = st;
    g.down     = (sw > dw) || (sh > dh);
    g.rowlen   = g.down ? dw : st;
    g.sw_m1    = CNT_W'(sw - DIM_W'(1));
    g.sh_m1    = CNT_W'(sh - DIM_W'(1));
    g.dx       = CNT_W'(gx >> 1);
    g.dy       = CNT_W'(gy >> 1);
    g.col_step = c.col_step;
    g.row_step = c.row_step;
    return g;
  endfunction

endpackage

// File: rtl/nslb_cfg.sv
module nslb_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [nslb_pkg::CIDX_W-1:0]      cfg_index_i,
  input  logic [nslb_pkg::CDATA_W-1:0]     cfg_data_i,
  output nslb_pkg::geom_t                  geom_o
);

  nslb_pkg::cfg_t  cfg_q;
  nslb_pkg::geom_t geom_q;

  assign cfg_ready_o = 1'b1;
  assign geom_o      = geom_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q  <= nslb_pkg::CFG_RESET;
      geom_q <= nslb_pkg::derive(nslb_pkg::CFG_RESET);
    end else begin
      geom_q <= nslb_pkg::derive(cfg_q);
      if (cfg_valid_i) begin
        unique case (nslb_pkg::cfg_idx_e'(cfg_index_i))
          nslb_pkg::CFG_SRC_WIDTH:  cfg_q.src_w    <= cfg_data_i[nslb_pkg::CFG_W-1:0];
          nslb_pkg::CFG_SRC_HEIGHT: cfg_q.src_h    <= cfg_data_i[nslb_pkg::CFG_W-1:0];
          nslb_pkg::CFG_SCR_WIDTH:  cfg_q.scr_w    <= cfg_data_i[nslb_pkg::CFG_W-1:0];
          nslb_pkg::CFG_SCR_HEIGHT: cfg_q.scr_h    <= cfg_data_i[nslb_pkg::CFG_W-1:0];
          nslb_pkg::CFG_SCR_STRIDE: cfg_q.stride   <= cfg_data_i[nslb_pkg::CFG_W-1:0];
          nslb_pkg::CFG_COL_STEP:   cfg_q.col_step <= cfg_data_i[nslb_pkg::STEP_W-1:0];
          nslb_pkg::CFG_ROW_STEP:   cfg_q.row_step <= cfg_data_i[nslb_pkg::STEP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

endmodule

// File: rtl/nslb_walk.sv
module nslb_walk (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  logic             restart_i,
  input  nslb_pkg::geom_t  geom_i,
  input  logic             take_i,
  output logic             pos_valid_o,
  output nslb_pkg::pos_t   pos_o
);

  localparam int CNT_W  = nslb_pkg::CNT_W;
  localparam int DIM_W  = nslb_pkg::DIM_W;
  localparam int STEP_W = nslb_pkg::STEP_W;

  logic              s1_valid_q;
  logic              s1_restart_q;
  logic [CNT_W-1:0]  col_q, col_d;
  logic [CNT_W-1:0]  row_q, row_d;
  logic [STEP_W-1:0] cacc_q, cacc_d;
  logic [STEP_W-1:0] racc_q, racc_d;

  logic              adv;
  logic              col_wrap, row_wrap;
  logic [CNT_W-1:0]  col_e, row_e;
  logic [STEP_W-1:0] cacc_e, racc_e;
  logic [DIM_W-1:0]  col_inc, row_inc;
  logic              last_col, last_row;
  logic [STEP_W:0]   csum, rsum;
  logic [STEP_W-1:0] csat, rsat;

  assign adv        = s1_valid_q && take_i;
  assign in_ready_o = !s1_valid_q || take_i;

  assign col_wrap = s1_restart_q || (DIM_W'(col_q) >= geom_i.rowlen);
  assign row_wrap = s1_restart_q || (DIM_W'(row_q) >= geom_i.dh);
  assign col_e    = col_wrap ? '0 : col_q;
  assign row_e    = row_wrap ? '0 : row_q;
  assign cacc_e   = col_wrap ? '0 : cacc_q;
  assign racc_e   = row_wrap ? '0 : racc_q;

  assign col_inc  = DIM_W'(col_e) + DIM_W'(1);
  assign row_inc  = DIM_W'(row_e) + DIM_W'(1);
  assign last_col = col_inc >= geom_i.rowlen;
  assign last_row = row_inc >= geom_i.dh;

  assign csum = {1'b0, cacc_e} + {1'b0, geom_i.col_step};
  assign rsum = {1'b0, racc_e} + {1'b0, geom_i.row_step};
  assign csat = csum[STEP_W] ? '1 : csum[STEP_W-1:0];
  assign rsat = rsum[STEP_W] ? '1 : rsum[STEP_W-1:0];

  always_comb begin
    col_d  = '0;
    cacc_d = '0;
    row_d  = row_e;
    racc_d = racc_e;
    if (!last_col) begin
      col_d  = CNT_W'(col_inc);
      cacc_d = csat;
    end else if (!last_row) begin
      row_d  = CNT_W'(row_inc);
      racc_d = rsat;
    end else begin
      row_d  = '0;
      racc_d = '0;
    end
    if (!geom_i.down) begin
      cacc_d = '0;
      racc_d = '0;
    end
  end

  assign pos_valid_o   = s1_valid_q;
  assign pos_o.row     = row_e;
  assign pos_o.col     = col_e;
  assign pos_o.col_acc = cacc_e;
  assign pos_o.row_acc = racc_e;
  assign pos_o.last    = last_col && last_row;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      col_q      <= '0;
      row_q      <= '0;
      cacc_q     <= '0;
      racc_q     <= '0;
    end else begin
      if (in_ready_o) begin
        s1_valid_q <= in_valid_i;
      end
      if (adv) begin
        col_q  <= col_d;
        row_q  <= row_d;
        cacc_q <= cacc_d;
        racc_q <= racc_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o) begin
      s1_restart_q <= restart_i;
    end
  end

endmodule

// File: rtl/nslb_addr.sv
module nslb_addr (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  nslb_pkg::geom_t               geom_i,
  input  logic                          pos_valid_i,
  input  nslb_pkg::pos_t                pos_i,
  output logic                          take_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nslb_pkg::ADDR_W-1:0]   dest_address_o,
  output logic [nslb_pkg::ADDR_W-1:0]   source_address_o,
  output logic                          fill_zero_o,
  output logic                          frame_end_o
);

  localparam int CNT_W  = nslb_pkg::CNT_W;
  localparam int DIM_W  = nslb_pkg::DIM_W;
  localparam int ADDR_W = nslb_pkg::ADDR_W;
  localparam int FRAC_W = nslb_pkg::FRAC_W;
  localparam int STEP_W = nslb_pkg::STEP_W;
  localparam int SPOS_W = nslb_pkg::SPOS_W;
  localparam int PROD_W = CNT_W + DIM_W;

  logic                   out_valid_q;
  logic [ADDR_W-1:0]      dest_q, dest_d;
  logic [ADDR_W-1:0]      src_q, src_d;
  logic                   fill_q, fill_d;
  logic                   end_q;

  logic [PROD_W-1:0]      dprod, sprod;
  logic [SPOS_W-1:0]      scol_raw, srow_raw;
  logic [CNT_W-1:0]       scol, srow;
  logic [CNT_W-1:0]       r, c;
  logic                   in_win;
  logic [CNT_W-1:0]       srow_sel, scol_sel;
  logic [ADDR_W-1:0]      src_sum;

  assign take_o = !out_valid_q || out_ready_i;

  assign dprod  = PROD_W'(pos_i.row) * PROD_W'(geom_i.st);
  assign dest_d = ADDR_W'(dprod) + ADDR_W'(pos_i.col);

  assign scol_raw = pos_i.col_acc[STEP_W-1:FRAC_W];
  assign srow_raw = pos_i.row_acc[STEP_W-1:FRAC_W];
  assign scol = (32'(scol_raw) > 32'(geom_i.sw_m1)) ? geom_i.sw_m1 : CNT_W'(scol_raw);
  assign srow = (32'(srow_raw) > 32'(geom_i.sh_m1)) ? geom_i.sh_m1 : CNT_W'(srow_raw);

  assign r      = pos_i.row - geom_i.dy;
  assign c      = pos_i.col - geom_i.dx;
  assign in_win = (pos_i.row >= geom_i.dy) && (32'(r) < 32'(geom_i.sh)) &&
                  (pos_i.col >= geom_i.dx) && (32'(c) < 32'(geom_i.sw));

  assign srow_sel = geom_i.down ? srow : r;
  assign scol_sel = geom_i.down ? scol : c;
  assign sprod    = PROD_W'(srow_sel) * PROD_W'(geom_i.sw);
  assign src_sum  = ADDR_W'(sprod) + ADDR_W'(scol_sel);
  assign fill_d   = !geom_i.down && !in_win;
  assign src_d    = fill_d ? '0 : src_sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take_o) begin
      out_valid_q <= pos_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_o && pos_valid_i) begin
      dest_q <= dest_d;
      src_q  <= src_d;
      fill_q <= fill_d;
      end_q  <= pos_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign dest_address_o   = dest_q;
  assign source_address_o = src_q;
  assign fill_zero_o      = fill_q;
  assign frame_end_o      = end_q;

endmodule

// File: rtl/nearest_scale_letterbox_blit.sv
// Write command generator for one frame blit from a source frame to a scanout surface.
// Each word taken on the input channel (in_valid_i/in_ready_o, restart_i) yields exactly
// one word on the output channel (out_valid_o/out_ready_i): a destination byte address,
// a source byte address, a zero-fill flag and a frame-end flag. Setting restart_i starts
// a new frame; otherwise the next position of the frame walk is used, wrapping after the
// word flagged frame_end_o. When the source is larger than the screen it is reduced by
// nearest-neighbour stepping; otherwise it is centred and the surrounding bytes are filled.
// The configuration channel (cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i) is always
// ready and should only be written while no word is in flight.
// A taken word passes through an input stage holding the frame position, then one
// multiply-and-add stage into the output register. Throughput is one word per cycle
// while the receiver does not stall; the position counters close their loop
// combinationally.
// When the receiver stalls, the output register holds its word and the input stage keeps
// one more word, so the input channel stops after one further word.
// Reset clears both stages and the frame position and loads the default geometry
// (320x240 source and screen, stride 320, unit steps).
module nearest_scale_letterbox_blit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          restart_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [nslb_pkg::ADDR_W-1:0]   dest_address_o,
  output logic [nslb_pkg::ADDR_W-1:0]   source_address_o,
  output logic                          fill_zero_o,
  output logic                          frame_end_o,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [nslb_pkg::CIDX_W-1:0]   cfg_index_i,
  input  logic [nslb_pkg::CDATA_W-1:0]  cfg_data_i
);

  nslb_pkg::geom_t geom;
  nslb_pkg::pos_t  pos;
  logic            pos_valid;
  logic            take;

  nslb_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .geom_o      (geom)
  );

  nslb_walk u_walk (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .restart_i   (restart_i),
    .geom_i      (geom),
    .take_i      (take),
    .pos_valid_o (pos_valid),
    .pos_o       (pos)
  );

  nslb_addr u_addr (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .geom_i           (geom),
    .pos_valid_i      (pos_valid),
    .pos_i            (pos),
    .take_o           (take),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .dest_address_o   (dest_address_o),
    .source_address_o (source_address_o),
    .fill_zero_o      (fill_zero_o),
    .frame_end_o      (frame_end_o)
  );

  // A filled word never carries a source address.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && fill_zero_o |-> source_address_o == '0)
    else $error("fill word with nonzero source address");

  // With the output register empty, the input stage always drains, so input is ready.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled while output register empty");

  // A word accepted into an empty pipeline passes the input stage and reaches the output.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !out_valid_o && !pos_valid |=> ##1 out_valid_o)
    else $error("accepted word did not reach the output");

endmodule
